[sv/cad_pkg.sv]
`default_nettype none

package cad_pkg;

    // Width of one stored element and of the data words on the channels.
    localparam int DATA_W = 32;

    // Width of the capacity register.
    localparam int CAP_W = 8;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    // Answer of a peek on an empty deque.
    localparam logic [DATA_W-1:0] PEEK_EMPTY = '1;

    // Register indexes of the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    // Operation codes of an input word.
    typedef enum logic [2:0] {
        FN_PUSH_REAR  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_REAR   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_REAR  = 3'd5
    } func_t;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

endpackage

`default_nettype wire

[sv/cad_ram.sv]
`default_nettype none

module cad_ram
    import cad_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/circular_array_deque.sv]
// Double-ended queue of 32-bit words held in a circular array of DEPTH slots, of which
// the first "capacity" slots are used (capacity 0 acts as 1, values above DEPTH act as
// DEPTH). Each input word carries one operation (push rear/front, pop rear/front, peek
// front/rear) and yields exactly one result word in the cycle after it is accepted: peeked
// data (-1 on an empty peek, 0 for a non-peek), a status (ok, overflow, underflow) and the
// full and empty flags after the operation. One word is accepted every cycle while the
// result side takes its words; each word makes at most one access to the element memory
// (a write for a push, a read at the accept edge of a peek), and the one output register
// holds a stalled result and then holds the input side too. The memory is not cleared
// after reset and the block is ready at once. Write capacity only while the block is idle.
`default_nettype none

module circular_array_deque
    import cad_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration port.
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    // Input channel.
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                func,
    input  wire logic signed [DATA_W-1:0]  value,
    // Output channel.
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [DATA_W-1:0]       data,
    output logic      [1:0]                status,
    output logic                           full_flag,
    output logic                           empty_flag
);

    localparam int IW = $clog2(DEPTH);
    localparam int EW = IW + 1;
    localparam int CW = (EW > CAP_W) ? EW : CAP_W;

    // Configuration register.
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;

    // Deque state.
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;

    // Output register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] data_reg, data_next;
    status_t           status_reg, status_next;
    logic              full_reg, full_next;
    logic              eflag_reg;
    logic              from_mem_reg, from_mem_next;

    // Memory port controls.
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic          accept;
    logic [CW-1:0] cap_ext;
    logic [CW-1:0] ecap_w;
    logic [EW-1:0] ecap;
    logic          full_now;

    // Index one step forward, wrapping at the effective capacity.
    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                               input logic [EW-1:0] c);
        logic [EW-1:0] s;
        s = {1'b0, i} + EW'(1);
        return (s >= c) ? '0 : s[IW-1:0];
    endfunction

    // Index one step back; an index outside the capacity lands on the last slot.
    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                               input logic [EW-1:0] c);
        logic [EW-1:0] last;
        last = c - EW'(1);
        return ((i == '0) || ({1'b0, i} >= c)) ? last[IW-1:0] : i - IW'(1);
    endfunction

    // Configuration write and read.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = 32'(cap_reg);
        end
    end

    // Effective capacity: zero acts as one, anything above DEPTH saturates.
    assign cap_ext = CW'(cap_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            ecap_w = CW'(1);
        end
        else if (cap_ext > CW'(DEPTH))
        begin
            ecap_w = CW'(DEPTH);
        end
        else
        begin
            ecap_w = cap_ext;
        end
    end

    assign ecap = ecap_w[EW-1:0];

    // Handshake: a stalled result holds the input side.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full_now = !empty_reg && (idx_next(tail_reg, ecap) == head_reg);

    // Operation decode: pointer update, memory access and result word.
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        data_next     = '0;
        status_next   = ST_OK;
        from_mem_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        if (accept)
        begin
            case (func_t'(func))
                FN_PUSH_REAR, FN_PUSH_FRONT:
                begin
                    if (full_now)
                    begin
                        status_next = ST_OVER;
                    end
                    else if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                    end
                    else if (func_t'(func) == FN_PUSH_REAR)
                    begin
                        tail_next = idx_next(tail_reg, ecap);
                        wr_en     = 1'b1;
                        wr_addr   = tail_next;
                    end
                    else
                    begin
                        head_next = idx_prev(head_reg, ecap);
                        wr_en     = 1'b1;
                        wr_addr   = head_next;
                    end
                end
                FN_POP_REAR, FN_POP_FRONT:
                begin
                    if (empty_reg)
                    begin
                        status_next = ST_UNDER;
                    end
                    else if (head_reg == tail_reg)
                    begin
                        empty_next = 1'b1;
                        head_next  = '0;
                        tail_next  = '0;
                    end
                    else if (func_t'(func) == FN_POP_REAR)
                    begin
                        tail_next = idx_prev(tail_reg, ecap);
                    end
                    else
                    begin
                        head_next = idx_next(head_reg, ecap);
                    end
                end
                FN_PEEK_FRONT, FN_PEEK_REAR:
                begin
                    if (empty_reg)
                    begin
                        status_next = ST_UNDER;
                        data_next   = PEEK_EMPTY;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = (func_t'(func) == FN_PEEK_FRONT) ? head_reg : tail_reg;
                        from_mem_next = 1'b1;
                    end
                end
                default:
                begin
                    // Unknown operation: no change, flags only.
                end
            endcase
        end
    end

    assign full_next = !empty_next && (idx_next(tail_next, ecap) == head_next);

    // Element memory.
    cad_ram #(
        .DEPTH   (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Deque state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; loads only with an accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg     <= data_next;
            status_reg   <= status_next;
            full_reg     <= full_next;
            eflag_reg    <= empty_next;
            from_mem_reg <= from_mem_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data       = from_mem_reg ? rd_data : data_reg;
    assign status     = status_reg;
    assign full_flag  = full_reg;
    assign empty_flag = eflag_reg;

    // An empty deque always has both indices at slot zero.
    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty deque with nonzero index");

    // A successful push leaves the deque non-empty.
    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (wr_en == 1'b1) |=> !empty_reg)
        else $error("deque empty after a push");

    // Popping the last element empties the deque.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !empty_reg && (head_reg == tail_reg)
        && ((func_t'(func) == FN_POP_REAR) || (func_t'(func) == FN_POP_FRONT))
        |=> empty_reg)
        else $error("deque not empty after popping the last element");

    // A reported result is never both full and empty, and has a defined status.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(full_reg && eflag_reg) && (status_reg != status_t'(2'd3)))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

[test/circular_array_deque_test.sv]
`timescale 1ns / 1ps

module circular_array_deque_test;
    import cad_pkg::*;

    localparam int SLOT_COUNT = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASES = 8;

    // Function codes that the block must treat as no operation.
    localparam logic [2:0] FN_UNUSED_A = 3'd6;
    localparam logic [2:0] FN_UNUSED_B = 3'd7;

    // One result word as the block should present it.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic              full;
        logic              empty;
    } result_t;

    // One row of the directed script: either a capacity write or an operation word,
    // the latter with an optional hand-typed result.
    typedef struct packed {
        logic              is_cfg;
        logic [2:0]        fn;
        logic [DATA_W-1:0] arg;
        logic              typed;
        result_t           want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] func = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_W-1:0] data;
    logic [1:0] status;
    logic full_flag;
    logic empty_flag;

    // Shadow state of the deque.
    logic [DATA_W-1:0] slot_mem [SLOT_COUNT];
    logic slot_written [SLOT_COUNT];
    int unsigned front_idx = 0;
    int unsigned rear_idx = 0;
    logic deque_empty = 1'b1;
    logic [CAP_W-1:0] cap_reg = CAP_RESET;

    result_t due_results[$];
    step_row_t script[$];

    int unsigned err_count = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned overflow_count = 0;
    int unsigned underflow_count = 0;
    int unsigned cap_writes = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    logic hold_go = 1'b0;
    logic no_gaps = 1'b0;

    int unsigned phase_cap [PHASES] = '{2, 3, 128, 5, 0, 255, 17, 0};
    int unsigned phase_len [PHASES] = '{40, 40, 170, 40, 30, 40, 50, 50};
    int unsigned phase_push [PHASES] = '{50, 45, 92, 40, 50, 20, 55, 50};

    circular_array_deque #(.DEPTH(SLOT_COUNT)) u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .data(data), .status(status),
        .full_flag(full_flag), .empty_flag(empty_flag)
    );

    always #4 clk = ~clk;

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, due_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 50)
            $display("Mismatch at cycle %0d on %s: got %h, expected %h",
                     cycle_count, what, got, want);
        err_count++;
    endtask

    // Capacity as the index arithmetic sees it.
    function automatic int unsigned eff_capacity();
        int unsigned c;
        c = cap_reg;
        if (c == 0) c = 1;
        if (c > SLOT_COUNT) c = SLOT_COUNT;
        return c;
    endfunction

    function automatic int unsigned idx_next(input int unsigned i);
        return (i + 1 >= eff_capacity()) ? 0 : i + 1;
    endfunction

    function automatic int unsigned idx_prev(input int unsigned i);
        if (i == 0 || i >= eff_capacity()) return eff_capacity() - 1;
        return i - 1;
    endfunction

    function automatic int unsigned slot_of(input int unsigned i);
        return (i < SLOT_COUNT) ? i : 0;
    endfunction

    function automatic logic deque_full();
        return !deque_empty && idx_next(rear_idx) == front_idx;
    endfunction

    function automatic void store_word(input int unsigned i, input logic [31:0] v);
        slot_mem[slot_of(i)] = v;
        slot_written[slot_of(i)] = 1'b1;
    endfunction

    // Applies one operation word to the shadow deque and returns its result word.
    function automatic result_t apply_deque_op(input logic [2:0] f, input logic [31:0] v);
        result_t r;
        r.data = '0;
        r.status = ST_OK;
        case (f)
            FN_PUSH_REAR, FN_PUSH_FRONT:
            begin
                if (deque_full())
                    r.status = ST_OVER;
                else if (deque_empty)
                begin
                    front_idx = 0;
                    rear_idx = 0;
                    deque_empty = 1'b0;
                    store_word(0, v);
                end
                else if (f == FN_PUSH_REAR)
                begin
                    rear_idx = idx_next(rear_idx);
                    store_word(rear_idx, v);
                end
                else
                begin
                    front_idx = idx_prev(front_idx);
                    store_word(front_idx, v);
                end
            end
            FN_POP_REAR, FN_POP_FRONT:
            begin
                if (deque_empty)
                    r.status = ST_UNDER;
                else if (front_idx == rear_idx)
                begin
                    deque_empty = 1'b1;
                    front_idx = 0;
                    rear_idx = 0;
                end
                else if (f == FN_POP_REAR)
                    rear_idx = idx_prev(rear_idx);
                else
                    front_idx = idx_next(front_idx);
            end
            FN_PEEK_FRONT, FN_PEEK_REAR:
            begin
                if (deque_empty)
                begin
                    r.status = ST_UNDER;
                    r.data = PEEK_EMPTY;
                end
                else
                    r.data = slot_mem[slot_of(f == FN_PEEK_FRONT ? front_idx : rear_idx)];
            end
            default: ;
        endcase
        if (r.status == ST_OVER) overflow_count++;
        if (r.status == ST_UNDER) underflow_count++;
        r.full = deque_full();
        r.empty = deque_empty;
        return r;
    endfunction

    // Picks a random operation; a peek that would land on a slot never written
    // is turned into a pop.
    function automatic logic [2:0] pick_op(input int unsigned push_pct);
        logic [2:0] f;
        int unsigned k;
        if ($urandom_range(0, 99) < 3)
            f = ($urandom_range(0, 1) != 0) ? FN_UNUSED_B : FN_UNUSED_A;
        else if ($urandom_range(0, 99) < push_pct)
            f = ($urandom_range(0, 1) != 0) ? FN_PUSH_FRONT : FN_PUSH_REAR;
        else
        begin
            case ($urandom_range(0, 3))
                0: f = FN_POP_REAR;
                1: f = FN_POP_FRONT;
                2: f = FN_PEEK_FRONT;
                default: f = FN_PEEK_REAR;
            endcase
        end
        if ((f == FN_PEEK_FRONT || f == FN_PEEK_REAR) && !deque_empty)
        begin
            k = slot_of(f == FN_PEEK_FRONT ? front_idx : rear_idx);
            if (!slot_written[k]) f = FN_POP_FRONT;
        end
        return f;
    endfunction

    // Offers one word, with a random gap first, and books its result on acceptance.
    task automatic send_word(input logic [2:0] f, input logic [31:0] v,
                             input logic typed, input result_t want);
        result_t r;
        no_gaps = (words_sent >= 300 && words_sent < 380);
        while (!no_gaps && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = apply_deque_op(f, v);
        due_results.push_back(typed ? want : r);
        words_sent++;
    endtask

    // Writes the capacity register once the block is idle, then reads it back.
    task automatic set_capacity(input logic [CAP_W-1:0] c);
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CAPACITY, 2'b00};
        pwdata <= {24'($urandom()), c};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cap_reg = c;
        cap_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[CAP_W-1:0] !== c)
            report_mismatch("capacity readback", prdata, {24'd0, c});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void op_row(input logic [2:0] f, input logic [31:0] v);
        step_row_t s;
        s = '0;
        s.fn = f;
        s.arg = v;
        script.push_back(s);
    endfunction

    function automatic void op_row_exp(input logic [2:0] f, input logic [31:0] v,
                                       input logic [31:0] d, input logic [1:0] st,
                                       input logic fu, input logic em);
        step_row_t s;
        s = '0;
        s.fn = f;
        s.arg = v;
        s.typed = 1'b1;
        s.want.data = d;
        s.want.status = st;
        s.want.full = fu;
        s.want.empty = em;
        script.push_back(s);
    endfunction

    function automatic void cap_row(input logic [CAP_W-1:0] c);
        step_row_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.arg = {24'd0, c};
        script.push_back(s);
    endfunction

    // Result side: random stalls, the long hold-off, and a quiet stretch.
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (no_gaps)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 22);
    end

    // Each accepted result word is compared with the oldest one owed.
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                report_mismatch("unexpected result word", data, '0);
            else
            begin
                w = due_results.pop_front();
                if (data !== w.data) report_mismatch("data", data, w.data);
                if (status !== w.status) report_mismatch("status", {30'd0, status},
                                                         {30'd0, w.status});
                if (full_flag !== w.full) report_mismatch("full_flag", {31'd0, full_flag},
                                                          {31'd0, w.full});
                if (empty_flag !== w.empty) report_mismatch("empty_flag",
                                                            {31'd0, empty_flag},
                                                            {31'd0, w.empty});
            end
            words_checked++;
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned p;
        int unsigned n;
        logic [CAP_W-1:0] c;
        logic [2:0] f;

        for (i = 0; i < SLOT_COUNT; i++)
        begin
            slot_mem[i] = '0;
            slot_written[i] = 1'b0;
        end

        // Empty deque at reset capacity: underflows, no-op codes, then the value extremes.
        op_row_exp(FN_PEEK_FRONT, 32'h1234_5678, PEEK_EMPTY, ST_UNDER, 1'b0, 1'b1);
        op_row_exp(FN_PEEK_REAR, '0, PEEK_EMPTY, ST_UNDER, 1'b0, 1'b1);
        op_row_exp(FN_POP_REAR, '0, '0, ST_UNDER, 1'b0, 1'b1);
        op_row_exp(FN_POP_FRONT, '1, '0, ST_UNDER, 1'b0, 1'b1);
        op_row_exp(FN_UNUSED_A, '1, '0, ST_OK, 1'b0, 1'b1);
        op_row_exp(FN_UNUSED_B, '0, '0, ST_OK, 1'b0, 1'b1);
        op_row_exp(FN_PUSH_REAR, 32'h7FFF_FFFF, '0, ST_OK, 1'b0, 1'b0);
        op_row_exp(FN_PUSH_FRONT, 32'h8000_0000, '0, ST_OK, 1'b0, 1'b0);
        op_row_exp(FN_PEEK_FRONT, '0, 32'h8000_0000, ST_OK, 1'b0, 1'b0);
        op_row_exp(FN_PEEK_REAR, '0, 32'h7FFF_FFFF, ST_OK, 1'b0, 1'b0);
        op_row(FN_PUSH_REAR, 32'hFFFF_FFFF);
        op_row(FN_PUSH_FRONT, 32'h0000_0000);
        op_row(FN_POP_REAR, '0);
        op_row(FN_POP_FRONT, '0);
        op_row(FN_PEEK_REAR, '0);
        op_row(FN_POP_FRONT, '0);
        op_row(FN_POP_REAR, '0);
        // Capacity zero behaves as a single slot.
        cap_row(8'd0);
        op_row_exp(FN_PUSH_FRONT, 32'h5A5A_5A5A, '0, ST_OK, 1'b1, 1'b0);
        op_row_exp(FN_PUSH_REAR, 32'h0000_0001, '0, ST_OVER, 1'b1, 1'b0);
        op_row_exp(FN_PEEK_REAR, '0, 32'h5A5A_5A5A, ST_OK, 1'b1, 1'b0);
        op_row_exp(FN_POP_REAR, '0, '0, ST_OK, 1'b0, 1'b1);
        // Capacity above the array size saturates.
        cap_row(8'd255);
        op_row_exp(FN_PUSH_REAR, 32'hA5A5_A5A5, '0, ST_OK, 1'b0, 1'b0);
        op_row(FN_POP_FRONT, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        for (i = 0; i < script.size(); i++)
        begin
            if (script[i].is_cfg)
                set_capacity(script[i].arg[CAP_W-1:0]);
            else
                send_word(script[i].fn, script[i].arg, script[i].typed, script[i].want);
        end

        // Random phases, each under its own capacity; contents carry over between them.
        for (p = 0; p < PHASES; p++)
        begin
            c = (p == PHASES - 1) ? CAP_W'($urandom_range(0, 255)) : CAP_W'(phase_cap[p]);
            set_capacity(c);
            for (n = 0; n < phase_len[p]; n++)
            begin
                if (phase_cap[p] == SLOT_COUNT && n == 20) hold_go = 1'b1;
                f = pick_op(phase_push[p]);
                send_word(f, $urandom(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d operation words (%0d results checked) over %0d capacity writes.",
                 words_sent, words_checked, cap_writes);
        $display("Saw %0d overflows and %0d underflows; %0d mismatches.",
                 overflow_count, underflow_count, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
